@@ rtl/hfr_pkg.sv @@
// hfr_pkg: shared types, constants and header tables for the frame receiver
// used by hfr_ctrl, hfr_datapath and the top level
package hfr_pkg;

  localparam int unsigned FRAME_MAX  = 9;
  localparam int unsigned FRAME_IW   = $clog2(FRAME_MAX);
  localparam int unsigned HEADER_LEN = 3;
  localparam logic [7:0]  PAD_CHAR   = 8'h20;

  localparam logic [2:0] KIND_OBE = 3'd0;
  localparam logic [2:0] KIND_DES = 3'd1;
  localparam logic [2:0] KIND_REP = 3'd2;
  localparam logic [2:0] KIND_PAR = 3'd3;
  localparam logic [2:0] KIND_FIN = 3'd4;
  localparam logic [2:0] KIND_TAN = 3'd5;
  localparam logic [2:0] KIND_NIT = 3'd6;
  localparam logic [2:0] KIND_ERR = 3'd7;

  typedef struct packed {
    logic load;
    logic step;
    logic clear;
  } hfr_cmd_t;

  typedef struct packed {
    logic frame_done;
    logic last_word;
  } hfr_status_t;

  typedef struct packed {
    logic       hit;
    logic [2:0] kind;
  } hfr_match_t;

  function automatic logic first_ok(input logic [7:0] c);
    logic ok;
    case (c)
      "O", "D", "R", "P", "F", "T", "E", "N": ok = 1'b1;
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

  function automatic logic second_ok(input logic [7:0] c);
    logic ok;
    case (c)
      "B", "E", "A", "I", "R": ok = 1'b1;
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

  function automatic hfr_match_t header_lookup(input logic [23:0] hdr);
    hfr_match_t m;
    m.hit = 1'b1;
    case (hdr)
      "OBE":   m.kind = KIND_OBE;
      "DES":   m.kind = KIND_DES;
      "REP":   m.kind = KIND_REP;
      "PAR":   m.kind = KIND_PAR;
      "FIN":   m.kind = KIND_FIN;
      "TAN":   m.kind = KIND_TAN;
      "NIT":   m.kind = KIND_NIT;
      "ERR":   m.kind = KIND_ERR;
      default: begin
        m.hit  = 1'b0;
        m.kind = KIND_OBE;
      end
    endcase
    return m;
  endfunction

  function automatic logic [2:0] payload_len(input logic [2:0] kind);
    logic [2:0] len;
    case (kind)
      KIND_OBE, KIND_ERR: len = 3'd6;
      KIND_NIT:           len = 3'd0;
      default:            len = 3'd3;
    endcase
    return len;
  endfunction

endpackage

@@ rtl/hfr_ctrl.sv @@
// hfr_ctrl: controller fsm, switches between taking bytes and sending a message
// depends on hfr_pkg for the command and status structs
module hfr_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  hfr_pkg::hfr_status_t status_i,
  output hfr_pkg::hfr_cmd_t    cmd_o
);

  typedef enum logic {
    ST_RECV,
    ST_EMIT
  } state_e;

  state_e state_q;
  logic   in_ready_q;
  logic   out_valid_q;

  always_comb begin
    cmd_o.load  = in_valid_i & in_ready_q;
    cmd_o.step  = out_valid_q & out_ready_i;
    cmd_o.clear = out_valid_q & out_ready_i & status_i.last_word;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RECV;
      in_ready_q  <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        ST_RECV: begin
          if (cmd_o.load && status_i.frame_done) begin
            state_q     <= ST_EMIT;
            in_ready_q  <= 1'b0;
            out_valid_q <= 1'b1;
          end
        end
        ST_EMIT: begin
          if (cmd_o.clear) begin
            state_q     <= ST_RECV;
            in_ready_q  <= 1'b1;
            out_valid_q <= 1'b0;
          end
        end
        default: begin
          state_q     <= ST_RECV;
          in_ready_q  <= 1'b1;
          out_valid_q <= 1'b0;
        end
      endcase
    end
  end

  assign in_ready_o  = in_ready_q;
  assign out_valid_o = out_valid_q;

endmodule

@@ rtl/hfr_datapath.sv @@
// hfr_datapath: frame store, header check, position and message word select
// depends on hfr_pkg; driven by hfr_ctrl commands
module hfr_datapath #(
  parameter int unsigned MESSAGE_BYTES = 9
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  hfr_pkg::hfr_cmd_t    cmd_i,
  input  logic [7:0]           rx_byte_i,
  output hfr_pkg::hfr_status_t status_o,
  output logic [7:0]           msg_byte_o,
  output logic                 last_o,
  output logic [2:0]           frame_kind_o
);

  localparam int unsigned IW = $clog2(MESSAGE_BYTES);

  logic [7:0]    store_q [hfr_pkg::FRAME_MAX];
  logic [3:0]    pos_q, pos_d;
  logic [2:0]    len_q, len_d;
  logic [2:0]    kind_q, kind_d;
  logic [IW-1:0] idx_q, idx_d;
  logic          zero_q, zero_d;

  logic                      wr_en;
  logic [hfr_pkg::FRAME_IW-1:0] wr_idx;
  logic [hfr_pkg::FRAME_IW-1:0] rd_idx;
  logic [3:0]                frame_end;
  logic [3:0]                pos_inc;
  logic                      in_frame;
  logic                      use_byte;
  logic [7:0]                rd_byte;
  hfr_pkg::hfr_match_t       match;

  assign frame_end = 4'(hfr_pkg::HEADER_LEN) + {1'b0, len_q};
  assign pos_inc   = pos_q + 4'd1;
  assign match     = hfr_pkg::header_lookup({store_q[0], store_q[1], rx_byte_i});

  assign in_frame = (idx_q < IW'(pos_q)) && (idx_q < IW'(hfr_pkg::FRAME_MAX));
  assign rd_idx   = in_frame ? idx_q[hfr_pkg::FRAME_IW-1:0] : '0;
  assign rd_byte  = store_q[rd_idx];
  assign use_byte = in_frame && !zero_q;

  assign msg_byte_o   = (use_byte && rd_byte != 8'd0) ? rd_byte : hfr_pkg::PAD_CHAR;
  assign last_o       = (idx_q == IW'(MESSAGE_BYTES - 1));
  assign frame_kind_o = kind_q;

  always_comb begin
    pos_d   = pos_q;
    len_d   = len_q;
    kind_d  = kind_q;
    idx_d   = idx_q;
    zero_d  = zero_q;
    wr_en   = 1'b0;
    wr_idx  = pos_q[hfr_pkg::FRAME_IW-1:0];
    status_o.last_word  = last_o;
    status_o.frame_done = 1'b0;
    if (cmd_i.load) begin
      if (pos_q == 4'd0) begin
        if (hfr_pkg::first_ok(rx_byte_i)) begin
          wr_en = 1'b1;
          pos_d = 4'd1;
        end
      end else if (pos_q == 4'd1) begin
        if (hfr_pkg::second_ok(rx_byte_i)) begin
          wr_en = 1'b1;
          pos_d = 4'd2;
        end else begin
          pos_d = 4'd0;
        end
      end else if (pos_q == 4'd2) begin
        wr_en = 1'b1;
        if (match.hit) begin
          pos_d  = 4'(hfr_pkg::HEADER_LEN);
          kind_d = match.kind;
          len_d  = hfr_pkg::payload_len(match.kind);
          status_o.frame_done = (hfr_pkg::payload_len(match.kind) == 3'd0);
        end else begin
          pos_d  = 4'd0;
          len_d  = 3'd0;
          kind_d = hfr_pkg::KIND_OBE;
        end
      end else begin
        if (pos_q < frame_end && pos_q < 4'(hfr_pkg::FRAME_MAX)) begin
          wr_en = 1'b1;
          pos_d = pos_inc;
        end
        status_o.frame_done = (pos_d >= frame_end) || (pos_d >= 4'(hfr_pkg::FRAME_MAX));
      end
    end
    if (cmd_i.step) begin
      idx_d  = idx_q + IW'(1);
      zero_d = zero_q | (use_byte && rd_byte == 8'd0);
    end
    if (cmd_i.clear) begin
      pos_d  = 4'd0;
      len_d  = 3'd0;
      kind_d = hfr_pkg::KIND_OBE;
      idx_d  = '0;
      zero_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= 4'd0;
      len_q  <= 3'd0;
      kind_q <= hfr_pkg::KIND_OBE;
      idx_q  <= '0;
      zero_q <= 1'b0;
    end else begin
      pos_q  <= pos_d;
      len_q  <= len_d;
      kind_q <= kind_d;
      idx_q  <= idx_d;
      zero_q <= zero_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_q[wr_idx] <= rx_byte_i;
    end
  end

endmodule

@@ rtl/header_typed_frame_receiver.sv @@
// header_typed_frame_receiver: top level, joins the controller and the datapath
// depends on hfr_pkg, hfr_ctrl and hfr_datapath
//
// Takes one received serial byte per input word and builds frames that open
// with a three-letter header (OBE, DES, REP, PAR, FIN, TAN, NIT, ERR). The
// byte that completes a frame is followed by MESSAGE_BYTES output words, one
// per cycle while out_ready_i is high, each with the frame kind and last_o on
// the final word; bytes past the stored frame, and from the first zero byte
// on, read as spaces. While a message is being sent in_ready_o is low, so no
// new byte is taken until the last word, counted by the single message word
// counter, has been accepted.
module header_typed_frame_receiver #(
  parameter int unsigned MESSAGE_BYTES = 9
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] rx_byte_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic [7:0] msg_byte_o,
  output logic       last_o,
  output logic [2:0] frame_kind_o,
  output logic       out_valid_o,
  input  logic       out_ready_i
);

  hfr_pkg::hfr_cmd_t    cmd;
  hfr_pkg::hfr_status_t status;

  hfr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  hfr_datapath #(
    .MESSAGE_BYTES (MESSAGE_BYTES)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .rx_byte_i    (rx_byte_i),
    .status_o     (status),
    .msg_byte_o   (msg_byte_o),
    .last_o       (last_o),
    .frame_kind_o (frame_kind_o)
  );

endmodule

@@ rtl/hfr_checker.sv @@
// hfr_checker: port level assertions for the frame receiver
// bound to header_typed_frame_receiver below
module hfr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic [7:0] msg_byte_o,
  input logic       last_o,
  input logic [2:0] frame_kind_o,
  input logic       out_valid_o,
  input logic       out_ready_i
);

  // input is held off while a message goes out
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while message pending");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(msg_byte_o) && $stable(last_o))
    else $error("stalled output word changed");

  a_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && last_o |=> !out_valid_o && in_ready_o)
    else $error("message did not end after last word");

  a_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_o |=> out_valid_o && $stable(frame_kind_o))
    else $error("message broken or kind changed");

endmodule

bind header_typed_frame_receiver hfr_checker u_hfr_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .msg_byte_o   (msg_byte_o),
  .last_o       (last_o),
  .frame_kind_o (frame_kind_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i)
);

@@ dv/hfr_checker.sv @@
// hfr_scoreboard: watches the byte and message channels of the frame receiver,
// predicts every message from the accepted bytes and compares it word by word
// depends on hfr_pkg
module hfr_scoreboard #(
  parameter int unsigned MSG_BYTES = 9
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] rx_byte_i,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic [7:0] msg_byte_i,
  input  logic       last_i,
  input  logic [2:0] frame_kind_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  output int         error_count_o,
  output int         pending_o
);

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       last;
    logic [2:0] kind;
  } msg_word_t;

  msg_word_t   msg_words_due[$];
  logic [3:0]  rx_pos;
  logic [2:0]  rx_len;
  logic [2:0]  rx_kind;
  logic [7:0]  rx_store [hfr_pkg::FRAME_MAX];
  logic [23:0] kind_name [8];
  logic [2:0]  kind_len [8];

  initial begin
    kind_name[hfr_pkg::KIND_OBE] = "OBE";  kind_len[hfr_pkg::KIND_OBE] = 3'd6;
    kind_name[hfr_pkg::KIND_DES] = "DES";  kind_len[hfr_pkg::KIND_DES] = 3'd3;
    kind_name[hfr_pkg::KIND_REP] = "REP";  kind_len[hfr_pkg::KIND_REP] = 3'd3;
    kind_name[hfr_pkg::KIND_PAR] = "PAR";  kind_len[hfr_pkg::KIND_PAR] = 3'd3;
    kind_name[hfr_pkg::KIND_FIN] = "FIN";  kind_len[hfr_pkg::KIND_FIN] = 3'd3;
    kind_name[hfr_pkg::KIND_TAN] = "TAN";  kind_len[hfr_pkg::KIND_TAN] = 3'd3;
    kind_name[hfr_pkg::KIND_NIT] = "NIT";  kind_len[hfr_pkg::KIND_NIT] = 3'd0;
    kind_name[hfr_pkg::KIND_ERR] = "ERR";  kind_len[hfr_pkg::KIND_ERR] = 3'd6;
  end

  function automatic logic lead_letter(input logic [7:0] c);
    case (c)
      "O", "D", "R", "P", "F", "T", "E", "N": return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic second_letter(input logic [7:0] c);
    case (c)
      "B", "E", "A", "I", "R": return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  task automatic clear_frame();
    rx_pos  = '0;
    rx_len  = '0;
    rx_kind = hfr_pkg::KIND_OBE;
    foreach (rx_store[i]) rx_store[i] = 8'h00;
  endtask

  // space padded, and blank from the first zero byte on
  task automatic emit_message();
    msg_word_t w;
    logic      zero_seen;
    zero_seen = 1'b0;
    for (int k = 0; k < MSG_BYTES; k++) begin
      w.msg_byte = hfr_pkg::PAD_CHAR;
      if (!zero_seen && k < hfr_pkg::FRAME_MAX && k < rx_pos) begin
        if (rx_store[k] == 8'h00) zero_seen = 1'b1;
        else w.msg_byte = rx_store[k];
      end
      w.last = (k == MSG_BYTES - 1);
      w.kind = rx_kind;
      msg_words_due.push_back(w);
    end
    clear_frame();
  endtask

  task automatic take_rx_byte(input logic [7:0] c);
    int hit;
    hit = -1;
    if (rx_pos == 4'd0) begin
      if (lead_letter(c)) begin
        rx_store[0] = c;
        rx_pos      = 4'd1;
      end
    end else if (rx_pos == 4'd1) begin
      if (second_letter(c)) begin
        rx_store[1] = c;
        rx_pos      = 4'd2;
      end else begin
        rx_pos = 4'd0;
      end
    end else if (rx_pos == 4'd2) begin
      rx_store[2] = c;
      rx_pos      = 4'(hfr_pkg::HEADER_LEN);
      for (int k = 0; k < 8; k++) begin
        if (hit < 0 && {rx_store[0], rx_store[1], rx_store[2]} == kind_name[k]) hit = k;
      end
      if (hit < 0) begin
        clear_frame();
      end else begin
        rx_kind = 3'(hit);
        rx_len  = kind_len[hit];
        if (rx_len == 3'd0) emit_message();
      end
    end else begin
      if (rx_pos < hfr_pkg::HEADER_LEN + rx_len && rx_pos < hfr_pkg::FRAME_MAX) begin
        rx_store[rx_pos] = c;
        rx_pos           = rx_pos + 4'd1;
      end
      if (rx_pos >= hfr_pkg::HEADER_LEN + rx_len || rx_pos >= hfr_pkg::FRAME_MAX) begin
        emit_message();
      end
    end
  endtask

  task automatic check_word();
    msg_word_t due;
    if (msg_words_due.size() == 0) begin
      $error("unexpected word: msg_byte %h last %b frame_kind %0d",
             msg_byte_i, last_i, frame_kind_i);
      error_count_o++;
    end else begin
      due = msg_words_due.pop_front();
      if (msg_byte_i !== due.msg_byte) begin
        $error("msg_byte: expected %h, got %h", due.msg_byte, msg_byte_i);
        error_count_o++;
      end
      if (last_i !== due.last) begin
        $error("last: expected %b, got %b", due.last, last_i);
        error_count_o++;
      end
      if (frame_kind_i !== due.kind) begin
        $error("frame_kind: expected %0d, got %0d", due.kind, frame_kind_i);
        error_count_o++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_frame();
      msg_words_due.delete();
      error_count_o = 0;
      pending_o     = 0;
    end else begin
      if (in_valid_i && in_ready_i) take_rx_byte(rx_byte_i);
      if (out_valid_i && out_ready_i) check_word();
      pending_o = msg_words_due.size();
    end
  end

endmodule

@@ dv/testbench.sv @@
// testbench: drives header-typed byte streams into the frame receiver with random
// idling on both sides and gives the verdict; depends on hfr_pkg, hfr_scoreboard
// and header_typed_frame_receiver
module testbench;

  localparam int unsigned MSG_BYTES    = 9;
  localparam int unsigned RANDOM_WORDS = 280;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 4 * MSG_BYTES;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic [7:0]  rx_byte   = 8'h00;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  logic [7:0]  msg_byte;
  logic        last;
  logic [2:0]  frame_kind;
  logic        out_valid;
  logic        out_ready = 1'b0;

  int          error_count;
  int          pending;
  int          cycles      = 0;
  int          sent_words  = 0;
  logic        long_hold   = 1'b0;
  logic        holding     = 1'b0;
  logic        burst_mode  = 1'b0;
  logic [23:0] frame_names [8];

  header_typed_frame_receiver #(
    .MESSAGE_BYTES(MSG_BYTES)
  ) u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .rx_byte_i   (rx_byte),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .msg_byte_o  (msg_byte),
    .last_o      (last),
    .frame_kind_o(frame_kind),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready)
  );

  hfr_scoreboard #(
    .MSG_BYTES(MSG_BYTES)
  ) u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .rx_byte_i    (rx_byte),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .msg_byte_i   (msg_byte),
    .last_i       (last),
    .frame_kind_i (frame_kind),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .error_count_o(error_count),
    .pending_o    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    if (burst_mode) return 0;
    r = $urandom_range(0, 19);
    if (r < 11) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] payload_byte();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(8'h21, 8'h7e));
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (!in_ready);
    sent_words++;
  endtask

  task automatic send_frame(input logic [2:0] kind);
    int len;
    len = (kind == hfr_pkg::KIND_NIT) ? 0 :
          (kind == hfr_pkg::KIND_OBE || kind == hfr_pkg::KIND_ERR) ? 6 : 3;
    send_byte(frame_names[kind][23:16]);
    send_byte(frame_names[kind][15:8]);
    send_byte(frame_names[kind][7:0]);
    repeat (len) send_byte(payload_byte());
  endtask

  // stray bytes and headers broken at the second or third letter
  task automatic send_noise();
    int         pick;
    logic [2:0] kind;
    pick = $urandom_range(0, 2);
    kind = 3'($urandom_range(0, 7));
    if (pick == 0) begin
      send_byte(8'($urandom));
    end else begin
      send_byte(frame_names[kind][23:16]);
      if (pick == 2) send_byte(frame_names[kind][15:8]);
      send_byte(8'($urandom));
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
  endtask

  initial begin
    int          r;
    logic        hold_done;
    logic [7:0]  directed [27];
    directed = '{8'h00, "O", 8'hff, "O", "B", "X", "O", "B", 8'h00, "N", "I", "T",
                 "O", "B", "E", "A", 8'hff, 8'h00, "C", "D", "E",
                 "D", "E", "S", 8'h7f, 8'h80, 8'h01};
    hold_done = 1'b0;
    frame_names[hfr_pkg::KIND_OBE] = "OBE";
    frame_names[hfr_pkg::KIND_DES] = "DES";
    frame_names[hfr_pkg::KIND_REP] = "REP";
    frame_names[hfr_pkg::KIND_PAR] = "PAR";
    frame_names[hfr_pkg::KIND_FIN] = "FIN";
    frame_names[hfr_pkg::KIND_TAN] = "TAN";
    frame_names[hfr_pkg::KIND_NIT] = "NIT";
    frame_names[hfr_pkg::KIND_ERR] = "ERR";

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) send_byte(directed[i]);
    wait_drained();

    while (sent_words < RANDOM_WORDS) begin
      if ($urandom_range(0, 5) == 0) burst_mode = ~burst_mode;
      if (!hold_done && sent_words >= RANDOM_WORDS / 2) begin
        // receiver stalls long while frames keep coming
        hold_done  = 1'b1;
        long_hold  = 1'b1;
        wait (holding);
        burst_mode = 1'b1;
        repeat (4) send_frame(3'($urandom_range(0, 7)));
        burst_mode = 1'b0;
        wait_drained();
      end else begin
        r = $urandom_range(0, 4);
        if (r == 0) send_noise();
        else send_frame(3'($urandom_range(0, 7)));
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    @(posedge rst_n);
    forever begin
      if (long_hold) begin
        out_ready <= 1'b0;
        holding   = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        holding   = 1'b0;
        long_hold = 1'b0;
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, ($urandom_range(0, 3) == 0) ? 60 : 12)) @(posedge clk);
        out_ready <= 1'b0;
        if ($urandom_range(0, 9) == 0) repeat ($urandom_range(10, 40)) @(posedge clk);
        else repeat ($urandom_range(1, 3)) @(posedge clk);
      end
    end
  end

endmodule
